[hw/rtl/msm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msm_pkg
// Types and constants shared by the threshold monitor modules.
// ----------------------------------------------------------------------------
package msm_pkg;

    // width of the shared add/subtract unit: covers age differences and
    // threshold plus or minus window
    localparam int ALU_W = 18;

    localparam int TEMP_W  = 12;
    localparam int WIN_W   = 10;
    localparam int AGE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCESS_WINDOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT_S = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORKING_S     = 3'd4;

    // input mode codes
    localparam logic MODE_READING = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    // sensor mark bits
    localparam int MARK_LOW      = 0;
    localparam int MARK_HIGH     = 1;
    localparam int MARK_TOO_MUCH = 2;

    typedef struct packed {
        logic                     mode;
        logic [1:0]               sensor_slot;
        logic signed [TEMP_W-1:0] temperature;
    } item_t;

    typedef struct packed {
        logic       reply_alert;
        logic [1:0] reply_slot;
        logic       heat_on;
        logic       cool_on;
        logic       too_much_error;
        logic       too_long_error;
    } result_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] threshold_low;
        logic signed [TEMP_W-1:0] threshold_high;
        logic [WIN_W-1:0]         excess_window;
        logic [AGE_W-1:0]         connect_timeout_s;
        logic [AGE_W-1:0]         max_working_s;
    } cfg_t;

endpackage

[hw/rtl/msm_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msm_alu
// Shared add/subtract unit with sign and greater-than-zero flags.
// ----------------------------------------------------------------------------
module msm_alu (
    input  logic signed [msm_pkg::ALU_W-1:0] a,
    input  logic signed [msm_pkg::ALU_W-1:0] b,
    input  logic                             sub,
    output logic signed [msm_pkg::ALU_W-1:0] y,
    output logic                             neg,
    output logic                             pos
);
    import msm_pkg::*;

    logic [ALU_W-1:0] b_op;

    assign b_op = sub ? ~b : b;
    assign y    = a + b_op + {{(ALU_W-1){1'b0}}, sub};
    assign neg  = y[ALU_W-1];
    assign pos  = !y[ALU_W-1] && (y != '0);

endmodule

[hw/rtl/msm_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msm_seq
// Sequencer and sensor state: classifies a reading, walks the sensor slots
// to aggregate, or walks them to age on a tick, all through one shared ALU.
// ----------------------------------------------------------------------------
module msm_seq #(
    parameter int SENSOR_COUNT = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  msm_pkg::item_t   item,
    input  msm_pkg::cfg_t    cfg,
    input  logic             res_taken,
    output logic             busy,
    output logic             res_valid,
    output msm_pkg::result_t res
);
    import msm_pkg::*;

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SENSOR_COUNT - 1);
    localparam logic [CNT_W-1:0] REQ_IDX  = CNT_W'(SENSOR_COUNT);
    localparam logic [4:0] SLOT_LIMIT = 5'(SENSOR_COUNT);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHI  = 4'd1;
    localparam logic [3:0] S_CLO  = 4'd2;
    localparam logic [3:0] S_SUM  = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_UPD  = 4'd5;
    localparam logic [3:0] S_AGG  = 4'd6;
    localparam logic [3:0] S_REQ  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_TICK = 4'd9;

    logic [3:0]       state_reg, state_next;
    item_t            item_reg, item_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             hi_hit_reg, hi_hit_next;
    logic             lo_hit_reg, lo_hit_next;
    logic             tm_reg, tm_next;
    logic             agg_low_reg, agg_low_next;
    logic             agg_high_reg, agg_high_next;
    logic             agg_much_reg, agg_much_next;
    logic             too_long_reg, too_long_next;
    logic signed [ALU_W-1:0] acc_reg, acc_next;
    logic [2:0]       marks_reg [SENSOR_COUNT];
    logic [2:0]       marks_next [SENSOR_COUNT];
    logic [AGE_W-1:0] age_reg [SENSOR_COUNT];
    logic [AGE_W-1:0] age_next [SENSOR_COUNT];
    logic [AGE_W-1:0] req_age_reg, req_age_next;

    logic signed [ALU_W-1:0] alu_a, alu_b, alu_y;
    logic             alu_sub, alu_neg, alu_pos;

    logic [IDX_W-1:0] walk_ix;
    logic [IDX_W-1:0] slot_ix;
    logic signed [ALU_W-1:0] temp_x, hi_x, lo_x, win_x;
    logic [AGE_W-1:0] req_age_eff;
    logic [AGE_W-1:0] tick_age;

    assign walk_ix = idx_reg[IDX_W-1:0];
    assign slot_ix = IDX_W'(item_reg.sensor_slot);
    assign temp_x  = ALU_W'(item_reg.temperature);
    assign hi_x    = ALU_W'(cfg.threshold_high);
    assign lo_x    = ALU_W'(cfg.threshold_low);
    assign win_x   = {{(ALU_W-WIN_W){1'b0}}, cfg.excess_window};
    assign req_age_eff = (agg_low_reg || agg_high_reg) ? req_age_reg : '0;
    assign tick_age = (idx_reg == REQ_IDX) ? req_age_reg : age_reg[walk_ix];

    msm_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y),
        .neg (alu_neg),
        .pos (alu_pos)
    );

    // operand selection for the shared unit
    always_comb
    begin
        alu_a   = temp_x;
        alu_b   = hi_x;
        alu_sub = 1'b1;
        case (state_reg)
            S_CHI:
            begin
                alu_a = temp_x;
                alu_b = hi_x;
            end
            S_CLO:
            begin
                alu_a = lo_x;
                alu_b = temp_x;
            end
            S_SUM:
            begin
                alu_a   = hi_hit_reg ? hi_x : lo_x;
                alu_b   = win_x;
                alu_sub = !hi_hit_reg;
            end
            S_CMP:
            begin
                alu_a = hi_hit_reg ? temp_x : acc_reg;
                alu_b = hi_hit_reg ? acc_reg : temp_x;
            end
            S_AGG:
            begin
                alu_a = {{(ALU_W-AGE_W){1'b0}}, cfg.connect_timeout_s};
                alu_b = {{(ALU_W-AGE_W){1'b0}}, age_reg[walk_ix]};
            end
            S_REQ:
            begin
                alu_a = {{(ALU_W-AGE_W){1'b0}}, req_age_eff};
                alu_b = {{(ALU_W-AGE_W){1'b0}}, cfg.max_working_s};
            end
            S_TICK:
            begin
                alu_a   = {{(ALU_W-AGE_W){1'b0}}, tick_age};
                alu_b   = {{(ALU_W-1){1'b0}}, 1'b1};
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_sub = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        hi_hit_next   = hi_hit_reg;
        lo_hit_next   = lo_hit_reg;
        tm_next       = tm_reg;
        agg_low_next  = agg_low_reg;
        agg_high_next = agg_high_reg;
        agg_much_next = agg_much_reg;
        too_long_next = too_long_reg;
        acc_next      = acc_reg;
        req_age_next  = req_age_reg;
        marks_next    = marks_reg;
        age_next      = age_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next   = item;
                    idx_next    = '0;
                    hi_hit_next = 1'b0;
                    lo_hit_next = 1'b0;
                    tm_next     = 1'b0;
                    if (item.mode == MODE_TICK)
                        state_next = S_TICK;
                    else if ({3'b000, item.sensor_slot} < SLOT_LIMIT)
                        state_next = S_CHI;
                end
            end
            S_CHI:
            begin
                if (alu_pos)
                begin
                    hi_hit_next = 1'b1;
                    state_next  = S_SUM;
                end
                else
                    state_next = S_CLO;
            end
            S_CLO:
            begin
                if (alu_pos)
                begin
                    lo_hit_next = 1'b1;
                    state_next  = S_SUM;
                end
                else
                    state_next = S_UPD;
            end
            S_SUM:
            begin
                acc_next   = alu_y;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                tm_next    = alu_pos;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (hi_hit_reg || lo_hit_reg)
                    marks_next[slot_ix] = marks_reg[slot_ix] | {tm_reg, hi_hit_reg, lo_hit_reg};
                else
                    marks_next[slot_ix] = '0;
                age_next[slot_ix] = '0;
                idx_next      = '0;
                agg_low_next  = 1'b0;
                agg_high_next = 1'b0;
                agg_much_next = 1'b0;
                state_next    = S_AGG;
            end
            S_AGG:
            begin
                // connected while age <= timeout
                if (!alu_neg)
                begin
                    if (marks_reg[walk_ix][MARK_LOW])
                        agg_low_next = 1'b1;
                    else if (marks_reg[walk_ix][MARK_HIGH])
                        agg_high_next = 1'b1;
                    if (marks_reg[walk_ix][MARK_TOO_MUCH])
                        agg_much_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                    state_next = S_REQ;
            end
            S_REQ:
            begin
                req_age_next  = req_age_eff;
                too_long_next = alu_pos;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (res_taken)
                    state_next = S_IDLE;
            end
            S_TICK:
            begin
                if (idx_reg == REQ_IDX)
                begin
                    if (req_age_reg != AGE_MAX)
                        req_age_next = alu_y[AGE_W-1:0];
                    state_next = S_IDLE;
                end
                else if (age_reg[walk_ix] != AGE_MAX)
                    age_next[walk_ix] = alu_y[AGE_W-1:0];
                idx_next = idx_reg + 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            hi_hit_reg   <= 1'b0;
            lo_hit_reg   <= 1'b0;
            tm_reg       <= 1'b0;
            agg_low_reg  <= 1'b0;
            agg_high_reg <= 1'b0;
            agg_much_reg <= 1'b0;
            too_long_reg <= 1'b0;
            req_age_reg  <= '0;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                marks_reg[i] <= '0;
                age_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            hi_hit_reg   <= hi_hit_next;
            lo_hit_reg   <= lo_hit_next;
            tm_reg       <= tm_next;
            agg_low_reg  <= agg_low_next;
            agg_high_reg <= agg_high_next;
            agg_much_reg <= agg_much_next;
            too_long_reg <= too_long_next;
            req_age_reg  <= req_age_next;
            marks_reg    <= marks_next;
            age_reg      <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        acc_reg  <= acc_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_OUT);

    always_comb
    begin
        res.reply_alert    = hi_hit_reg || lo_hit_reg;
        res.reply_slot     = item_reg.sensor_slot;
        res.heat_on        = agg_low_reg;
        res.cool_on        = agg_high_reg;
        res.too_much_error = agg_much_reg;
        res.too_long_error = too_long_reg;
    end

endmodule

[hw/rtl/multi_sensor_threshold_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_sensor_threshold_monitor
// Threshold monitor over a set of temperature sensors with heat, cool and
// error aggregation.
// ----------------------------------------------------------------------------
// Usage:
// - item channel (valid/ready) carries a reading (mode 0, slot, temperature
//   in 1/16 degree) or a one-second tick (mode 1). item_ready is high only
//   while the sequencer is idle; one request is worked on at a time.
// - result channel (valid/ready) returns one result per reading in range;
//   ticks and readings for an absent slot give none.
// - result_valid rises once a taken reading has gone through the threshold
//   compares, a connect check per slot and a check of the request timer, all
//   through one shared ALU; a reading above the high limit takes more steps
//   than one inside limits, one below the low limit more still. The next
//   request is taken once the result has gone to the output register.
// - A tick keeps the sequencer busy while it makes one saturating increment
//   per age, the sensor ages first and the request timer last.
// - The result sits in an output register; the next request is taken while
//   it waits. A stalled receiver holds the sequencer in its last step only
//   once a second result is ready.
// - Reset clears marks and ages and loads the register defaults.
// - Config writes (cfg_wr_en, cfg_index, cfg_wdata) are for idle periods.
// ----------------------------------------------------------------------------
module multi_sensor_threshold_monitor #(
    parameter int SENSOR_COUNT = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  msm_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output msm_pkg::result_t                  result,
    input  logic                              cfg_wr_en,
    input  logic [msm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [msm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import msm_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    result_t result_reg;
    logic    result_valid_reg, result_valid_next;

    logic    seq_busy;
    logic    seq_res_valid;
    result_t seq_res;
    logic    res_taken;
    logic    start;

    assign item_ready = !seq_busy;
    assign start      = item_valid && item_ready;
    assign res_taken  = seq_res_valid && (!result_valid_reg || result_ready);

    msm_seq #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg       (cfg_reg),
        .res_taken (res_taken),
        .busy      (seq_busy),
        .res_valid (seq_res_valid),
        .res       (seq_res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_THRESHOLD_LOW:     cfg_next.threshold_low     = cfg_wdata[TEMP_W-1:0];
                CFG_THRESHOLD_HIGH:    cfg_next.threshold_high    = cfg_wdata[TEMP_W-1:0];
                CFG_EXCESS_WINDOW:     cfg_next.excess_window     = cfg_wdata[WIN_W-1:0];
                CFG_CONNECT_TIMEOUT_S: cfg_next.connect_timeout_s = cfg_wdata[AGE_W-1:0];
                CFG_MAX_WORKING_S:     cfg_next.max_working_s     = cfg_wdata[AGE_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (res_taken)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_low     <= 12'sd240;
            cfg_reg.threshold_high    <= 12'sd480;
            cfg_reg.excess_window     <= 10'd80;
            cfg_reg.connect_timeout_s <= 16'd300;
            cfg_reg.max_working_s     <= 16'd3600;
            result_valid_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
            result_reg <= seq_res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[tb/msm_reply_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msm_reply_checker
// Watches the item, result and register ports of the threshold monitor, keeps
// its own copy of the sensor marks, ages and request timer, predicts the reply
// to each accepted in-range reading and compares every result field by field.
// ----------------------------------------------------------------------------
module msm_reply_checker #(
    parameter int SENSOR_COUNT = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_ready,
    input  msm_pkg::item_t                 item,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  msm_pkg::result_t               result,
    input  logic                           cfg_wr_en,
    input  logic [msm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             mismatches,
    output int                             outstanding
);
    import msm_pkg::*;

    cfg_t             shadow_regs;
    logic [2:0]       slot_flags [SENSOR_COUNT];
    logic [AGE_W-1:0] slot_age [SENSOR_COUNT];
    logic [AGE_W-1:0] demand_age;
    result_t          awaited_replies [$];

    function automatic logic [AGE_W-1:0] bump_age(input logic [AGE_W-1:0] age);
        return (age == AGE_MAX) ? age : age + 1'b1;
    endfunction

    task automatic clear_state();
        shadow_regs.threshold_low     = 12'sd240;
        shadow_regs.threshold_high    = 12'sd480;
        shadow_regs.excess_window     = 10'd80;
        shadow_regs.connect_timeout_s = 16'd300;
        shadow_regs.max_working_s     = 16'd3600;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            slot_flags[i] = '0;
            slot_age[i]   = '0;
        end
        demand_age = '0;
        awaited_replies.delete();
        mismatches  = 0;
        outstanding = 0;
    endtask

    task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_THRESHOLD_LOW:     shadow_regs.threshold_low     = data[TEMP_W-1:0];
            CFG_THRESHOLD_HIGH:    shadow_regs.threshold_high    = data[TEMP_W-1:0];
            CFG_EXCESS_WINDOW:     shadow_regs.excess_window     = data[WIN_W-1:0];
            CFG_CONNECT_TIMEOUT_S: shadow_regs.connect_timeout_s = data[AGE_W-1:0];
            CFG_MAX_WORKING_S:     shadow_regs.max_working_s     = data[AGE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic age_all();
        for (int i = 0; i < SENSOR_COUNT; i++)
            slot_age[i] = bump_age(slot_age[i]);
        demand_age = bump_age(demand_age);
    endtask

    function automatic result_t predict_reply(input item_t req);
        int         temp, lo, hi, win;
        logic [2:0] flags;
        logic       low_seen, high_seen, excess_seen;
        result_t    reply;
        temp  = $signed(req.temperature);
        lo    = $signed(shadow_regs.threshold_low);
        hi    = $signed(shadow_regs.threshold_high);
        win   = shadow_regs.excess_window;
        reply = '0;
        flags = slot_flags[req.sensor_slot];
        // the high test wins, also when the thresholds are crossed
        if (temp > hi)
        begin
            if (temp > hi + win)
                flags[MARK_TOO_MUCH] = 1'b1;
            flags[MARK_HIGH]  = 1'b1;
            reply.reply_alert = 1'b1;
        end
        else if (temp < lo)
        begin
            if (temp < lo - win)
                flags[MARK_TOO_MUCH] = 1'b1;
            flags[MARK_LOW]   = 1'b1;
            reply.reply_alert = 1'b1;
        end
        else
            flags = '0;
        slot_flags[req.sensor_slot] = flags;
        slot_age[req.sensor_slot]   = '0;

        low_seen    = 1'b0;
        high_seen   = 1'b0;
        excess_seen = 1'b0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            if (slot_age[i] <= shadow_regs.connect_timeout_s)
            begin
                // a sensor with both marks only asks for heat
                if (slot_flags[i][MARK_LOW])
                    low_seen = 1'b1;
                else if (slot_flags[i][MARK_HIGH])
                    high_seen = 1'b1;
                if (slot_flags[i][MARK_TOO_MUCH])
                    excess_seen = 1'b1;
            end
        end
        if (!low_seen && !high_seen)
            demand_age = '0;

        reply.reply_slot     = req.sensor_slot;
        reply.heat_on        = low_seen;
        reply.cool_on        = high_seen;
        reply.too_much_error = excess_seen;
        reply.too_long_error = demand_age > shadow_regs.max_working_s;
        return reply;
    endfunction

    task automatic compare_field(input string field, input logic [1:0] want,
                                 input logic [1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reply(input result_t got);
        result_t want;
        if (awaited_replies.size() == 0)
        begin
            $error("reply for slot %0d with no request awaiting one", got.reply_slot);
            mismatches++;
            return;
        end
        want = awaited_replies.pop_front();
        compare_field("reply_alert",    want.reply_alert,    got.reply_alert);
        compare_field("reply_slot",     want.reply_slot,     got.reply_slot);
        compare_field("heat_on",        want.heat_on,        got.heat_on);
        compare_field("cool_on",        want.cool_on,        got.cool_on);
        compare_field("too_much_error", want.too_much_error, got.too_much_error);
        compare_field("too_long_error", want.too_long_error, got.too_long_error);
    endtask

    // a reply leaving at the same edge as a request arrives belongs to an earlier one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_state();
        else
        begin
            if (result_valid && result_ready)
                check_reply(result);
            if (item_valid && item_ready)
            begin
                if (item.mode == MODE_TICK)
                    age_all();
                else if (item.sensor_slot < SENSOR_COUNT)
                    awaited_replies.push_back(predict_reply(item));
            end
            if (cfg_wr_en)
                load_register(cfg_index, cfg_wdata);
            outstanding = awaited_replies.size();
        end
    end

endmodule

[tb/multi_sensor_threshold_monitor_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_sensor_threshold_monitor_test
// Drives readings and ticks into the threshold monitor with random gaps and
// result stalls: a directed set of boundary readings, then random phases
// under changing thresholds and timeouts.
// The reply checker beside the block reports the mismatch count.
// ----------------------------------------------------------------------------
module multi_sensor_threshold_monitor_test;
    import msm_pkg::*;

    localparam int SLOTS            = 4;
    localparam int TEMP_MIN         = -880;
    localparam int TEMP_MAX         = 2000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int PHASES           = 10;
    localparam int PHASE_ITEMS      = 125;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_THRESHOLD_LOW;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;

    cfg_t regs;
    bit   quiet_source = 1'b0;
    bit   quiet_sink   = 1'b0;
    int   mismatches;
    int   outstanding;
    int   idle_cycles  = 0;

    multi_sensor_threshold_monitor #(.SENSOR_COUNT(SLOTS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    msm_reply_checker #(.SENSOR_COUNT(SLOTS)) reply_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: hold ready low for a drawn number of cycles of a waiting reply
    initial
    begin
        int unsigned hold;
        hold = $urandom_range(0, 12);
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            result_ready <= (hold == 0);
            @(posedge clk);
            if (result_valid && result_ready)
                hold = quiet_sink ? 0 : $urandom_range(0, 12);
            else if (result_valid && hold != 0)
                hold--;
        end
    end

    task automatic push_item(input item_t req);
        int unsigned gap;
        gap = quiet_source ? 0 : $urandom_range(0, 12);
        repeat (gap) @(negedge clk);
        @(negedge clk);
        item       <= req;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    task automatic send_reading(input int slot, input int temp);
        item_t req;
        req.mode        = MODE_READING;
        req.sensor_slot = slot[1:0];
        req.temperature = temp[TEMP_W-1:0];
        push_item(req);
    endtask

    // slot and temperature of a tick are don't-care, so they carry noise
    task automatic send_tick();
        item_t req;
        req             = item_t'($urandom);
        req.mode        = MODE_TICK;
        push_item(req);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input int lo, input int hi, input int win,
                            input int timeout, input int max_work);
        regs.threshold_low     = lo[TEMP_W-1:0];
        regs.threshold_high    = hi[TEMP_W-1:0];
        regs.excess_window     = win[WIN_W-1:0];
        regs.connect_timeout_s = timeout[AGE_W-1:0];
        regs.max_working_s     = max_work[AGE_W-1:0];
        write_reg(CFG_THRESHOLD_LOW,
                  {{(CFG_DATA_W-TEMP_W){regs.threshold_low[TEMP_W-1]}}, regs.threshold_low});
        write_reg(CFG_THRESHOLD_HIGH,
                  {{(CFG_DATA_W-TEMP_W){regs.threshold_high[TEMP_W-1]}}, regs.threshold_high});
        write_reg(CFG_EXCESS_WINDOW, CFG_DATA_W'(regs.excess_window));
        write_reg(CFG_CONNECT_TIMEOUT_S, regs.connect_timeout_s);
        write_reg(CFG_MAX_WORKING_S, regs.max_working_s);
    endtask

    // a tick gives no reply, so allow the sequencer to finish one after the last reply
    task automatic drain_block();
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int pick_temperature();
        int lo, hi, win, temp, pick;
        lo   = $signed(regs.threshold_low);
        hi   = $signed(regs.threshold_high);
        win  = regs.excess_window;
        pick = $urandom_range(0, 5);
        case (pick)
            0:       temp = lo;
            1:       temp = hi;
            2:       temp = lo - win;
            3:       temp = hi + win;
            default: temp = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
        endcase
        if (pick < 4)
            temp += int'($urandom_range(0, 6)) - 3;
        if (temp < TEMP_MIN)
            temp = TEMP_MIN;
        if (temp > TEMP_MAX)
            temp = TEMP_MAX;
        return temp;
    endfunction

    task automatic run_random_phase(input int phase);
        int lo, hi, spare, win, timeout, max_work;
        lo = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
        hi = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
        // mostly ordered limits, now and then crossed
        if ($urandom_range(0, 4) != 0 && lo > hi)
        begin
            spare = lo;
            lo    = hi;
            hi    = spare;
        end
        case (phase)
            0:
            begin
                win      = 0;
                timeout  = 1;
                max_work = 1;
            end
            1:
            begin
                win      = 800;
                timeout  = 65535;
                max_work = 65535;
            end
            default:
            begin
                win      = $urandom_range(0, 800);
                timeout  = $urandom_range(1, 10);
                max_work = $urandom_range(1, 30);
            end
        endcase
        set_regs(lo, hi, win, timeout, max_work);
        quiet_source = (phase % 4 == 3);
        quiet_sink   = (phase % 4 >= 2);
        repeat (PHASE_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                send_tick();
            else
                send_reading($urandom_range(0, SLOTS - 1), pick_temperature());
        end
        drain_block();
    endtask

    initial
    begin
        regs.threshold_low     = 12'sd240;
        regs.threshold_high    = 12'sd480;
        regs.excess_window     = 10'd80;
        regs.connect_timeout_s = 16'd300;
        regs.max_working_s     = 16'd3600;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);

        // limits at reset: just past each limit, past each window edge, on the edges
        send_reading(0, 360);
        send_reading(1, 481);
        send_reading(1, 561);
        send_reading(2, 239);
        send_reading(2, 159);
        send_reading(2, TEMP_MAX);      // low and high both stuck on slot 2
        send_reading(3, TEMP_MIN);
        send_reading(1, 480);
        send_reading(2, 240);
        send_reading(3, 560);
        send_tick();
        send_reading(0, 160);
        drain_block();

        // crossed limits, no window, short timeouts
        set_regs(600, 100, 0, 2, 1);
        send_reading(0, 300);
        send_reading(1, 50);
        send_tick();
        send_tick();
        send_reading(2, 100);
        send_tick();
        send_reading(3, 600);
        send_tick();
        send_reading(2, 100);
        drain_block();

        set_regs(TEMP_MIN, TEMP_MAX, 800, 1, 65535);
        send_reading(0, TEMP_MAX);
        send_reading(1, TEMP_MIN);
        send_tick();
        send_reading(2, 0);
        drain_block();

        for (int phase = 0; phase < PHASES; phase++)
            run_random_phase(phase);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
